// ===== rtl/core/s2cd_pkg.sv =====
// ----------------------------------------------------------------------------
// s2cd_pkg
// Constants, types and calendar tables for the seconds to calendar date block.
// ----------------------------------------------------------------------------
package s2cd_pkg;

    localparam int unsigned SEC_W     = 32;
    localparam int unsigned DAY_SHIFT = 7;
    localparam int unsigned Q_W       = SEC_W - DAY_SHIFT;
    localparam int unsigned DAYS_W    = 16;
    localparam int unsigned TOD_W     = 17;

    // 86400 = 128 * 675, floor(q / 675) = (q * RECIP_675) >> 36 for q < 2**25
    localparam logic [26:0] RECIP_675   = 27'd101806633;
    localparam int unsigned SH_675      = 36;
    localparam logic [9:0]  DIV_675     = 10'd675;

    // floor(d / 1461) = (d * RECIP_1461) >> 28 for d < 2**16
    localparam logic [17:0] RECIP_1461  = 18'd183735;
    localparam int unsigned SH_1461     = 28;
    localparam logic [10:0] DAYS_QUAD   = 11'd1461;

    // 3600 = 16 * 225, floor(t / 225) = (t * RECIP_225) >> 22 for t < 2**13
    localparam logic [14:0] RECIP_225   = 15'd18642;
    localparam int unsigned SH_225      = 22;
    localparam logic [11:0] SECS_HOUR   = 12'd3600;

    // 60 = 4 * 15, floor(t / 15) = (t * RECIP_15) >> 16 for t < 2**10
    localparam logic [12:0] RECIP_15    = 13'd4370;
    localparam int unsigned SH_15       = 16;
    localparam logic [5:0]  SECS_MIN    = 6'd60;

    localparam logic [15:0] DAYS_TOTAL  = 16'd36525;
    localparam logic [11:0] FIRST_YEAR  = 12'd2000;
    localparam logic [10:0] YEAR1_END   = 11'd366;
    localparam logic [10:0] YEAR2_END   = 11'd731;
    localparam logic [10:0] YEAR3_END   = 11'd1096;
    localparam logic [1:0]  YQ_LEAP     = 2'd0;
    localparam logic [3:0]  FEB         = 4'd2;
    localparam int unsigned MONTHS      = 12;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
    } t_md;

    typedef struct packed {
        logic en;
    } t_pipe_ctl;

    // first day of year of each month, common year, index 0 is january
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        unique case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] month_first(input logic [3:0] idx, input logic leap);
        logic [8:0] v;
        v = month_start(idx);
        if (leap && idx >= FEB) begin
            v = v + 9'd1;
        end
        return v;
    endfunction

    function automatic t_md month_day(input logic [8:0] doy, input logic leap);
        t_md        res;
        logic [3:0] cnt;
        logic [8:0] base;
        cnt = 4'd0;
        for (int i = 1; i < MONTHS; i++) begin
            if (doy >= month_first(4'(i), leap)) begin
                cnt = cnt + 4'd1;
            end
        end
        base      = month_first(cnt, leap);
        res.month = cnt + 4'd1;
        res.day   = 5'(doy - base) + 5'd1;
        return res;
    endfunction

endpackage

// ===== rtl/core/s2cd_div_day.sv =====
// ----------------------------------------------------------------------------
// s2cd_div_day
// Splits the second count into whole days and second of day in two stages.
// ----------------------------------------------------------------------------
module s2cd_div_day (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  s2cd_pkg::t_pipe_ctl           i_ctl,
    input  logic                          i_vld,
    input  logic [s2cd_pkg::SEC_W-1:0]    i_secs,
    output logic                          o_vld,
    output logic [s2cd_pkg::DAYS_W-1:0]   o_days,
    output logic [s2cd_pkg::TOD_W-1:0]    o_tod
);

    logic                               r_a_vld;
    logic [51:0]                        r_a_prod;
    logic [s2cd_pkg::Q_W-1:0]           r_a_q;
    logic [s2cd_pkg::DAY_SHIFT-1:0]     r_a_lo;
    logic                               r_b_vld;
    logic [s2cd_pkg::DAYS_W-1:0]        r_b_days;
    logic [s2cd_pkg::TOD_W-1:0]         r_b_tod;

    logic [s2cd_pkg::Q_W-1:0]           n_q;
    logic [51:0]                        n_prod;
    logic [s2cd_pkg::DAYS_W-1:0]        n_days;
    logic [25:0]                        n_back;
    logic [9:0]                         n_rem;

    assign n_q    = i_secs[s2cd_pkg::SEC_W-1:s2cd_pkg::DAY_SHIFT];
    assign n_prod = 52'(n_q) * 52'(s2cd_pkg::RECIP_675);
    assign n_days = r_a_prod[s2cd_pkg::SH_675 +: s2cd_pkg::DAYS_W];
    assign n_back = 26'(n_days) * 26'(s2cd_pkg::DIV_675);
    assign n_rem  = 10'(r_a_q - n_back[s2cd_pkg::Q_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a_prod <= n_prod;
            r_a_q    <= n_q;
            r_a_lo   <= i_secs[s2cd_pkg::DAY_SHIFT-1:0];
            r_b_days <= n_days;
            r_b_tod  <= {n_rem, r_a_lo};
        end
    end

    assign o_vld  = r_b_vld;
    assign o_days = r_b_days;
    assign o_tod  = r_b_tod;

endmodule

// ===== rtl/core/s2cd_split.sv =====
// ----------------------------------------------------------------------------
// s2cd_split
// Splits days into four-year cycles and second of day into hours.
// ----------------------------------------------------------------------------
module s2cd_split (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  s2cd_pkg::t_pipe_ctl           i_ctl,
    input  logic                          i_vld,
    input  logic [s2cd_pkg::DAYS_W-1:0]   i_days,
    input  logic [s2cd_pkg::TOD_W-1:0]    i_tod,
    output logic                          o_vld,
    output logic [5:0]                    o_quad,
    output logic [10:0]                   o_qday,
    output logic [4:0]                    o_hour,
    output logic [11:0]                   o_rem_hour,
    output logic                          o_oor
);

    logic                               r_c_vld;
    logic [33:0]                        r_c_qprod;
    logic [27:0]                        r_c_hprod;
    logic [s2cd_pkg::DAYS_W-1:0]        r_c_days;
    logic [s2cd_pkg::TOD_W-1:0]         r_c_tod;
    logic                               r_c_oor;
    logic                               r_d_vld;
    logic [5:0]                         r_d_quad;
    logic [10:0]                        r_d_qday;
    logic [4:0]                         r_d_hour;
    logic [11:0]                        r_d_rem;
    logic                               r_d_oor;

    logic [33:0]                        n_qprod;
    logic [27:0]                        n_hprod;
    logic [5:0]                         n_quad;
    logic [4:0]                         n_hour;
    logic [16:0]                        n_qback;
    logic [16:0]                        n_hback;

    assign n_qprod = 34'(i_days) * 34'(s2cd_pkg::RECIP_1461);
    assign n_hprod = 28'(i_tod[s2cd_pkg::TOD_W-1:4]) * 28'(s2cd_pkg::RECIP_225);
    assign n_quad  = r_c_qprod[s2cd_pkg::SH_1461 +: 6];
    assign n_hour  = r_c_hprod[s2cd_pkg::SH_225 +: 5];
    assign n_qback = 17'(n_quad) * 17'(s2cd_pkg::DAYS_QUAD);
    assign n_hback = 17'(n_hour) * 17'(s2cd_pkg::SECS_HOUR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_c_vld <= i_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_c_qprod <= n_qprod;
            r_c_hprod <= n_hprod;
            r_c_days  <= i_days;
            r_c_tod   <= i_tod;
            r_c_oor   <= (i_days >= s2cd_pkg::DAYS_TOTAL);
            r_d_quad  <= n_quad;
            r_d_qday  <= 11'(r_c_days - n_qback[15:0]);
            r_d_hour  <= n_hour;
            r_d_rem   <= 12'(r_c_tod - n_hback);
            r_d_oor   <= r_c_oor;
        end
    end

    assign o_vld      = r_d_vld;
    assign o_quad     = r_d_quad;
    assign o_qday     = r_d_qday;
    assign o_hour     = r_d_hour;
    assign o_rem_hour = r_d_rem;
    assign o_oor      = r_d_oor;

endmodule

// ===== rtl/core/s2cd_date.sv =====
// ----------------------------------------------------------------------------
// s2cd_date
// Finds year, month and day, minute and second, and registers the result.
// ----------------------------------------------------------------------------
module s2cd_date (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  s2cd_pkg::t_pipe_ctl    i_ctl,
    input  logic                   i_vld,
    input  logic [5:0]             i_quad,
    input  logic [10:0]            i_qday,
    input  logic [4:0]             i_hour,
    input  logic [11:0]            i_rem_hour,
    input  logic                   i_oor,
    output logic                   o_vld,
    output logic [11:0]            o_year,
    output logic [3:0]             o_month,
    output logic [4:0]             o_day,
    output logic [4:0]             o_hour,
    output logic [5:0]             o_minute,
    output logic [5:0]             o_second,
    output logic                   o_oor
);

    logic           r_e_vld;
    logic [11:0]    r_e_year;
    logic [8:0]     r_e_doy;
    logic           r_e_leap;
    logic [22:0]    r_e_mprod;
    logic [11:0]    r_e_rem;
    logic [4:0]     r_e_hour;
    logic           r_e_oor;
    logic           r_f_vld;
    logic [11:0]    r_f_year;
    logic [3:0]     r_f_month;
    logic [4:0]     r_f_day;
    logic [4:0]     r_f_hour;
    logic [5:0]     r_f_minute;
    logic [5:0]     r_f_second;
    logic           r_f_oor;

    logic [1:0]     n_yq;
    logic [10:0]    n_ybase;
    logic [22:0]    n_mprod;
    logic [5:0]     n_minute;
    logic [11:0]    n_mback;
    s2cd_pkg::t_md  n_md;

    always_comb begin
        priority if (i_qday < s2cd_pkg::YEAR1_END) begin
            n_yq    = 2'd0;
            n_ybase = 11'd0;
        end else if (i_qday < s2cd_pkg::YEAR2_END) begin
            n_yq    = 2'd1;
            n_ybase = s2cd_pkg::YEAR1_END;
        end else if (i_qday < s2cd_pkg::YEAR3_END) begin
            n_yq    = 2'd2;
            n_ybase = s2cd_pkg::YEAR2_END;
        end else begin
            n_yq    = 2'd3;
            n_ybase = s2cd_pkg::YEAR3_END;
        end
    end

    assign n_mprod  = 23'(i_rem_hour[11:2]) * 23'(s2cd_pkg::RECIP_15);
    assign n_minute = r_e_mprod[s2cd_pkg::SH_15 +: 6];
    assign n_mback  = 12'(n_minute) * 12'(s2cd_pkg::SECS_MIN);
    assign n_md     = s2cd_pkg::month_day(r_e_doy, r_e_leap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_e_vld <= i_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_e_year   <= s2cd_pkg::FIRST_YEAR + {4'd0, i_quad, n_yq};
            r_e_doy    <= 9'(i_qday - n_ybase);
            r_e_leap   <= (n_yq == s2cd_pkg::YQ_LEAP);
            r_e_mprod  <= n_mprod;
            r_e_rem    <= i_rem_hour;
            r_e_hour   <= i_hour;
            r_e_oor    <= i_oor;
            r_f_year   <= r_e_oor ? 12'd0 : r_e_year;
            r_f_month  <= r_e_oor ? 4'd0 : n_md.month;
            r_f_day    <= r_e_oor ? 5'd0 : n_md.day;
            r_f_hour   <= r_e_hour;
            r_f_minute <= n_minute;
            r_f_second <= 6'(r_e_rem - n_mback);
            r_f_oor    <= r_e_oor;
        end
    end

    assign o_vld    = r_f_vld;
    assign o_year   = r_f_year;
    assign o_month  = r_f_month;
    assign o_day    = r_f_day;
    assign o_hour   = r_f_hour;
    assign o_minute = r_f_minute;
    assign o_second = r_f_second;
    assign o_oor    = r_f_oor;

endmodule

// ===== rtl/core/seconds_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Converts seconds since 2000-01-01 00:00:00 into Gregorian date and time.
//
// One input channel (i_valid / o_ready, i_elapsed_seconds) and one output
// channel (o_valid / i_ready, year to second plus o_out_of_range), each word
// moving when valid and ready are both high. Every input word gives exactly
// one output word, in order.
// A new word is taken every cycle while the output is not stalled; the block
// is a six-stage pipeline (day split, day remainder, year-cycle and hour
// products, their remainders, year and minute, month and second).
// When the receiver holds i_ready low with a word waiting, the whole pipeline
// holds and o_ready falls; nothing is dropped or repeated, and the empty
// pipeline keeps taking words.
// Reset clears all valid bits; the block then accepts at once.
// Counts at or past the end of 2099 raise o_out_of_range with year, month
// and day at zero; hour, minute and second still give the time of day.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [31:0]  i_elapsed_seconds,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [11:0]  o_year,
    output logic [3:0]   o_month,
    output logic [4:0]   o_day,
    output logic [4:0]   o_hour,
    output logic [5:0]   o_minute,
    output logic [5:0]   o_second,
    output logic         o_out_of_range
);

    s2cd_pkg::t_pipe_ctl            ctl;
    logic                           day_vld;
    logic [s2cd_pkg::DAYS_W-1:0]    day_days;
    logic [s2cd_pkg::TOD_W-1:0]     day_tod;
    logic                           spl_vld;
    logic [5:0]                     spl_quad;
    logic [10:0]                    spl_qday;
    logic [4:0]                     spl_hour;
    logic [11:0]                    spl_rem;
    logic                           spl_oor;

    assign ctl.en  = !o_valid || i_ready;
    assign o_ready = ctl.en;

    s2cd_div_day u_div_day (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_vld   (i_valid),
        .i_secs  (i_elapsed_seconds),
        .o_vld   (day_vld),
        .o_days  (day_days),
        .o_tod   (day_tod)
    );

    s2cd_split u_split (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_vld      (day_vld),
        .i_days     (day_days),
        .i_tod      (day_tod),
        .o_vld      (spl_vld),
        .o_quad     (spl_quad),
        .o_qday     (spl_qday),
        .o_hour     (spl_hour),
        .o_rem_hour (spl_rem),
        .o_oor      (spl_oor)
    );

    s2cd_date u_date (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_vld      (spl_vld),
        .i_quad     (spl_quad),
        .i_qday     (spl_qday),
        .i_hour     (spl_hour),
        .i_rem_hour (spl_rem),
        .i_oor      (spl_oor),
        .o_vld      (o_valid),
        .o_year     (o_year),
        .o_month    (o_month),
        .o_day      (o_day),
        .o_hour     (o_hour),
        .o_minute   (o_minute),
        .o_second   (o_second),
        .o_oor      (o_out_of_range)
    );

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_year == 12'd0 && o_month == 4'd0 && o_day == 5'd0)
        else $error("out of range word carries a date");

    a_date_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_of_range |-> o_month >= 4'd1 && o_month <= 4'd12
            && o_day >= 5'd1 && o_year >= 12'd2000 && o_year <= 12'd2099)
        else $error("date field out of range");

    a_time_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hour < 5'd24 && o_minute < 6'd60 && o_second < 6'd60)
        else $error("time field out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid word after reset");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("pipeline advances while output stalled");

endmodule
